FILE: sv/lfb_pkg.sv
// shared types and constants for the linear fog blend core
package lfb_pkg;

	localparam int DEPTH_BITS_DEF = 16;
	localparam int FACTOR_FRAC_BITS_DEF = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_NEAR_MAX_W = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FOG_ENABLE = 3'd0,
		REG_FOG_NEAR = 3'd1,
		REG_FOG_FAR = 3'd2,
		REG_FOG_RED = 3'd3,
		REG_FOG_GREEN = 3'd4,
		REG_FOG_BLUE = 3'd5
	} cfg_reg_t;

	localparam logic [CFG_NEAR_MAX_W-1:0] RST_FOG_NEAR = 16'd200;
	localparam logic [CFG_NEAR_MAX_W-1:0] RST_FOG_FAR = 16'd1200;
	localparam logic [7:0] RST_FOG_RED = 8'd128;
	localparam logic [7:0] RST_FOG_GREEN = 8'd128;
	localparam logic [7:0] RST_FOG_BLUE = 8'd144;

	typedef enum logic [1:0] {
		MODE_ZERO = 2'd0,
		MODE_ONE = 2'd1,
		MODE_DIV = 2'd2
	} fog_mode_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pix_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} fog_color_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} link_t;

endpackage

FILE: sv/lfb_prep.sv
// entry cell: range, depth offset and clamp decision for one item
module lfb_prep #(
	parameter int DEPTH_BITS = lfb_pkg::DEPTH_BITS_DEF,
	parameter int NEAR_W = lfb_pkg::CFG_NEAR_MAX_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DEPTH_BITS-1:0] depth,
	input  lfb_pkg::pix_t         pix,
	input  logic                  fog_enable,
	input  logic [NEAR_W-1:0]     fog_near,
	input  logic [NEAR_W-1:0]     fog_far,
	output lfb_pkg::link_t        link,
	input  logic                  out_ready,
	output logic [NEAR_W-1:0]     rem,
	output logic [NEAR_W-1:0]     range,
	output lfb_pkg::fog_mode_t    mode,
	output lfb_pkg::pix_t         pix_out
);

	logic [NEAR_W-1:0]     range_c;
	logic [DEPTH_BITS-1:0] near_ext;
	logic [DEPTH_BITS-1:0] diff_c;
	lfb_pkg::fog_mode_t    mode_c;
	logic                  valid_q;
	logic [NEAR_W-1:0]     rem_q;
	logic [NEAR_W-1:0]     range_q;
	lfb_pkg::fog_mode_t    mode_q;
	lfb_pkg::pix_t         pix_q;

	always_comb begin
		range_c = (fog_far > fog_near) ? (fog_far - fog_near) : NEAR_W'(1);
		near_ext = DEPTH_BITS'(fog_near);
		diff_c = depth - near_ext;
		if (!fog_enable || depth <= near_ext) begin
			mode_c = lfb_pkg::MODE_ZERO;
		end else if (diff_c >= DEPTH_BITS'(range_c)) begin
			mode_c = lfb_pkg::MODE_ONE;
		end else begin
			mode_c = lfb_pkg::MODE_DIV;
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rem_q <= diff_c[NEAR_W-1:0];
			range_q <= range_c;
			mode_q <= mode_c;
			pix_q <= pix;
		end
	end

	assign link = '{valid: valid_q, ready: in_ready};
	assign rem = rem_q;
	assign range = range_q;
	assign mode = mode_q;
	assign pix_out = pix_q;

endmodule

FILE: sv/lfb_div_cell.sv
// division cell: one restoring step, one quotient bit per cell
module lfb_div_cell #(
	parameter int NEAR_W = lfb_pkg::CFG_NEAR_MAX_W,
	parameter int FACTOR_FRAC_BITS = lfb_pkg::FACTOR_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [NEAR_W-1:0]           rem_in,
	input  logic [NEAR_W-1:0]           range_in,
	input  logic [FACTOR_FRAC_BITS-1:0] quot_in,
	input  lfb_pkg::fog_mode_t          mode_in,
	input  lfb_pkg::pix_t               pix_in,
	output lfb_pkg::link_t              link,
	input  logic                        out_ready,
	output logic [NEAR_W-1:0]           rem_out,
	output logic [NEAR_W-1:0]           range_out,
	output logic [FACTOR_FRAC_BITS-1:0] quot_out,
	output lfb_pkg::fog_mode_t          mode_out,
	output lfb_pkg::pix_t               pix_out
);

	logic [NEAR_W:0]             rem2_c;
	logic                        ge_c;
	logic [NEAR_W:0]             rem_next_c;
	logic                        valid_q;
	logic [NEAR_W-1:0]           rem_q;
	logic [NEAR_W-1:0]           range_q;
	logic [FACTOR_FRAC_BITS-1:0] quot_q;
	lfb_pkg::fog_mode_t          mode_q;
	lfb_pkg::pix_t               pix_q;

	always_comb begin
		rem2_c = {rem_in, 1'b0};
		ge_c = rem2_c >= {1'b0, range_in};
		rem_next_c = ge_c ? (rem2_c - {1'b0, range_in}) : rem2_c;
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			// remainder stays below range, so the top bit drops out
			rem_q <= rem_next_c[NEAR_W-1:0];
			range_q <= range_in;
			quot_q <= {quot_in[FACTOR_FRAC_BITS-2:0], ge_c};
			mode_q <= mode_in;
			pix_q <= pix_in;
		end
	end

	assign link = '{valid: valid_q, ready: in_ready};
	assign rem_out = rem_q;
	assign range_out = range_q;
	assign quot_out = quot_q;
	assign mode_out = mode_q;
	assign pix_out = pix_q;

endmodule

FILE: sv/lfb_mix.sv
// exit cell: factor select, color blend and output register
module lfb_mix #(
	parameter int FACTOR_FRAC_BITS = lfb_pkg::FACTOR_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [FACTOR_FRAC_BITS-1:0] quot_in,
	input  lfb_pkg::fog_mode_t          mode_in,
	input  lfb_pkg::pix_t               pix_in,
	input  lfb_pkg::fog_color_t         fog_color,
	output logic                        out_valid,
	input  logic                        out_stall,
	output lfb_pkg::pix_t               pix_out,
	output logic [FACTOR_FRAC_BITS:0]   factor_out
);

	localparam int TW = FACTOR_FRAC_BITS + 1;
	localparam int SW = TW + 9;
	localparam logic [TW-1:0] ONE = TW'(1) << FACTOR_FRAC_BITS;

	logic [TW-1:0]      t_c;
	logic [TW-1:0]      inv_c;
	logic [SW-1:0]      sum_r_c;
	logic [SW-1:0]      sum_g_c;
	logic [SW-1:0]      sum_b_c;
	logic               valid_q;
	lfb_pkg::pix_t      pix_q;
	logic [TW-1:0]      t_q;

	always_comb begin
		unique case (mode_in)
			lfb_pkg::MODE_ZERO: t_c = '0;
			lfb_pkg::MODE_ONE: t_c = ONE;
			lfb_pkg::MODE_DIV: t_c = {1'b0, quot_in};
			default: t_c = '0;
		endcase
		inv_c = ONE - t_c;
		sum_r_c = SW'(pix_in.red) * SW'(inv_c) + SW'(fog_color.red) * SW'(t_c);
		sum_g_c = SW'(pix_in.green) * SW'(inv_c) + SW'(fog_color.green) * SW'(t_c);
		sum_b_c = SW'(pix_in.blue) * SW'(inv_c) + SW'(fog_color.blue) * SW'(t_c);
	end

	assign in_ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pix_q.red <= sum_r_c[FACTOR_FRAC_BITS+7:FACTOR_FRAC_BITS];
			pix_q.green <= sum_g_c[FACTOR_FRAC_BITS+7:FACTOR_FRAC_BITS];
			pix_q.blue <= sum_b_c[FACTOR_FRAC_BITS+7:FACTOR_FRAC_BITS];
			pix_q.alpha <= pix_in.alpha;
			t_q <= t_c;
		end
	end

	assign out_valid = valid_q;
	assign pix_out = pix_q;
	assign factor_out = t_q;

endmodule

FILE: sv/linear_fog_blend_core.sv
// top level of the linear depth fog blend core
//
// One pixel item enters on the in channel (depth plus RGBA8) and one item
// leaves on the out channel (fogged RGB, alpha, applied factor), in order.
// Both channels use valid/stall; an item moves on an edge with valid high
// and stall low. The datapath is a row of cells: one entry cell that forms
// the range and clamp decision, FACTOR_FRAC_BITS division cells each giving
// one quotient bit, and a blend cell that also holds the output register.
// One item is taken every cycle in which in_stall is low.
// Every cell holds one item and moves it on when the next cell is empty or
// moving, so a stalled receiver fills the row from the end and in_stall
// rises only when every cell is full; bubbles close up meanwhile.
// The user must write registers (cfg_wr_en/cfg_index/cfg_data) only while the
// core is empty; the core does not enforce it. Unknown indexes are ignored.
// Reset empties all cells, loads fog off, near 200, far 1200, color 128/128/144.
module linear_fog_blend_core #(
	parameter int DEPTH_BITS = lfb_pkg::DEPTH_BITS_DEF,
	parameter int FACTOR_FRAC_BITS = lfb_pkg::FACTOR_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [DEPTH_BITS-1:0]               depth,
	input  logic [7:0]                          pixel_red,
	input  logic [7:0]                          pixel_green,
	input  logic [7:0]                          pixel_blue,
	input  logic [7:0]                          pixel_alpha,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          out_red,
	output logic [7:0]                          out_green,
	output logic [7:0]                          out_blue,
	output logic [7:0]                          out_alpha,
	output logic [FACTOR_FRAC_BITS:0]           fog_factor,
	input  logic                                cfg_wr_en,
	input  logic [lfb_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [lfb_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int NEAR_W = (DEPTH_BITS < lfb_pkg::CFG_NEAR_MAX_W) ?
		DEPTH_BITS : lfb_pkg::CFG_NEAR_MAX_W;
	localparam int F = FACTOR_FRAC_BITS;

	logic                fog_enable_q;
	logic [NEAR_W-1:0]   fog_near_q;
	logic [NEAR_W-1:0]   fog_far_q;
	lfb_pkg::fog_color_t fog_color_q;

	lfb_pkg::pix_t       pix_in;
	lfb_pkg::pix_t       pix_res;
	logic                entry_ready;
	logic                mix_ready;

	lfb_pkg::link_t      link [0:F];
	logic [NEAR_W-1:0]   rem_w [0:F];
	logic [NEAR_W-1:0]   range_w [0:F];
	logic [F-1:0]        quot_w [0:F];
	lfb_pkg::fog_mode_t  mode_w [0:F];
	lfb_pkg::pix_t       pix_w [0:F];
	logic                ready_w [0:F];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fog_enable_q <= 1'b0;
			fog_near_q <= lfb_pkg::RST_FOG_NEAR[NEAR_W-1:0];
			fog_far_q <= lfb_pkg::RST_FOG_FAR[NEAR_W-1:0];
			fog_color_q <= '{red: lfb_pkg::RST_FOG_RED, green: lfb_pkg::RST_FOG_GREEN,
				blue: lfb_pkg::RST_FOG_BLUE};
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				lfb_pkg::REG_FOG_ENABLE: fog_enable_q <= cfg_data[0];
				lfb_pkg::REG_FOG_NEAR: fog_near_q <= cfg_data[NEAR_W-1:0];
				lfb_pkg::REG_FOG_FAR: fog_far_q <= cfg_data[NEAR_W-1:0];
				lfb_pkg::REG_FOG_RED: fog_color_q.red <= cfg_data[7:0];
				lfb_pkg::REG_FOG_GREEN: fog_color_q.green <= cfg_data[7:0];
				lfb_pkg::REG_FOG_BLUE: fog_color_q.blue <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign pix_in = '{red: pixel_red, green: pixel_green, blue: pixel_blue,
		alpha: pixel_alpha};
	assign quot_w[0] = '0;

	lfb_prep #(
		.DEPTH_BITS(DEPTH_BITS),
		.NEAR_W(NEAR_W)
	) u_prep (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(entry_ready),
		.depth(depth),
		.pix(pix_in),
		.fog_enable(fog_enable_q),
		.fog_near(fog_near_q),
		.fog_far(fog_far_q),
		.link(link[0]),
		.out_ready(ready_w[0]),
		.rem(rem_w[0]),
		.range(range_w[0]),
		.mode(mode_w[0]),
		.pix_out(pix_w[0])
	);

	for (genvar i = 0; i < F; i++) begin : g_div
		lfb_div_cell #(
			.NEAR_W(NEAR_W),
			.FACTOR_FRAC_BITS(F)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(link[i].valid),
			.in_ready(ready_w[i]),
			.rem_in(rem_w[i]),
			.range_in(range_w[i]),
			.quot_in(quot_w[i]),
			.mode_in(mode_w[i]),
			.pix_in(pix_w[i]),
			.link(link[i+1]),
			.out_ready(i == F - 1 ? mix_ready : ready_w[i+1]),
			.rem_out(rem_w[i+1]),
			.range_out(range_w[i+1]),
			.quot_out(quot_w[i+1]),
			.mode_out(mode_w[i+1]),
			.pix_out(pix_w[i+1])
		);
	end

	assign ready_w[F] = mix_ready;

	lfb_mix #(
		.FACTOR_FRAC_BITS(F)
	) u_mix (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(link[F].valid),
		.in_ready(mix_ready),
		.quot_in(quot_w[F]),
		.mode_in(mode_w[F]),
		.pix_in(pix_w[F]),
		.fog_color(fog_color_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pix_out(pix_res),
		.factor_out(fog_factor)
	);

	assign in_stall = !entry_ready;
	assign out_red = pix_res.red;
	assign out_green = pix_res.green;
	assign out_blue = pix_res.blue;
	assign out_alpha = pix_res.alpha;

	// with the receiver taking items the whole row moves
	a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	a_factor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fog_factor <= ((F+1)'(1) << F))
		else $error("fog factor above one");

	a_entry_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> link[0].valid)
		else $error("accepted item missing from entry cell");

	a_last_cell_drains: assert property (@(posedge clk) disable iff (!arst_n)
		link[F].valid && !out_valid |=> out_valid)
		else $error("item lost between division row and blend cell");

endmodule

FILE: bench/tb_linear_fog_blend_core.sv
`timescale 1ns / 100ps
// self-checking testbench for linear_fog_blend_core with its own fog predictor
module tb_linear_fog_blend_core;

	localparam int FRAC = lfb_pkg::FACTOR_FRAC_BITS_DEF;
	localparam int LATENCY = FRAC + 2;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam logic [63:0] FACTOR_ONE = 64'd1 << FRAC;
	localparam logic [lfb_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 3'd6;
	localparam logic [lfb_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;

	typedef struct packed {
		lfb_pkg::pix_t pix;
		logic [FRAC:0] factor;
	} fogged_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] depth = '0;
	logic [7:0] pixel_red = '0;
	logic [7:0] pixel_green = '0;
	logic [7:0] pixel_blue = '0;
	logic [7:0] pixel_alpha = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;
	logic [FRAC:0] fog_factor;
	logic cfg_wr_en = 1'b0;
	logic [lfb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [lfb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// copy of the core's settings
	logic fog_on = 1'b0;
	logic [15:0] fog_near_q = lfb_pkg::RST_FOG_NEAR;
	logic [15:0] fog_far_q = lfb_pkg::RST_FOG_FAR;
	lfb_pkg::fog_color_t fog_rgb = {lfb_pkg::RST_FOG_RED, lfb_pkg::RST_FOG_GREEN,
		lfb_pkg::RST_FOG_BLUE};

	fogged_t pending_fogged[$];
	int fail_count = 0;
	int idle_cycles = 0;
	bit tx_idle_on = 1'b0;
	bit rx_idle_on = 1'b0;
	bit hold_request = 1'b0;
	int hold_len = 0;

	linear_fog_blend_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.depth(depth),
		.pixel_red(pixel_red),
		.pixel_green(pixel_green),
		.pixel_blue(pixel_blue),
		.pixel_alpha(pixel_alpha),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue),
		.out_alpha(out_alpha),
		.fog_factor(fog_factor),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [7:0] blend_channel(input logic [7:0] orig, input logic [7:0] tint,
			input logic [63:0] amount);
		logic [63:0] acc;
		acc = 64'(orig) * (FACTOR_ONE - amount) + 64'(tint) * amount;
		return acc[FRAC +: 8];
	endfunction

	function automatic fogged_t fog_pixel(input logic [15:0] d, input lfb_pkg::pix_t px);
		logic [63:0] span;
		logic [63:0] diff;
		logic [63:0] amount;
		fogged_t res;
		amount = '0;
		res.pix = px;
		if (fog_on) begin
			span = (fog_far_q > fog_near_q) ? 64'(fog_far_q - fog_near_q) : 64'd1;
			if (d > fog_near_q) begin
				diff = 64'(d - fog_near_q);
				amount = (diff >= span) ? FACTOR_ONE : (diff << FRAC) / span;
			end
			res.pix.red = blend_channel(px.red, fog_rgb.red, amount);
			res.pix.green = blend_channel(px.green, fog_rgb.green, amount);
			res.pix.blue = blend_channel(px.blue, fog_rgb.blue, amount);
		end
		res.factor = amount[FRAC:0];
		return res;
	endfunction

	function automatic lfb_pkg::pix_t random_pixel();
		return {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
	endfunction

	// depths mostly around the fog ramp, the rest anywhere
	function automatic logic [15:0] random_depth();
		int unsigned lo;
		int unsigned hi;
		if ($urandom_range(0, 2) == 0)
			return 16'($urandom);
		lo = (fog_near_q > 4) ? fog_near_q - 4 : 0;
		hi = (fog_far_q > fog_near_q) ? fog_far_q + 4 : fog_near_q + 4;
		if (hi > 16'hFFFF)
			hi = 16'hFFFF;
		return 16'($urandom_range(hi, lo));
	endfunction

	task automatic check_field(input string name, input logic [16:0] want, input logic [16:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t %s: expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	task automatic send_pixel(input logic [15:0] d, input lfb_pkg::pix_t px);
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		depth <= d;
		pixel_red <= px.red;
		pixel_green <= px.green;
		pixel_blue <= px.blue;
		pixel_alpha <= px.alpha;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_core_empty();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_fogged.size() != 0) @(posedge clk);
	endtask

	task automatic write_fog_reg(input logic [lfb_pkg::CFG_INDEX_W-1:0] idx,
			input logic [lfb_pkg::CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			lfb_pkg::REG_FOG_ENABLE: fog_on = data[0];
			lfb_pkg::REG_FOG_NEAR: fog_near_q = data[15:0];
			lfb_pkg::REG_FOG_FAR: fog_far_q = data[15:0];
			lfb_pkg::REG_FOG_RED: fog_rgb.red = data[7:0];
			lfb_pkg::REG_FOG_GREEN: fog_rgb.green = data[7:0];
			lfb_pkg::REG_FOG_BLUE: fog_rgb.blue = data[7:0];
			default: ;
		endcase
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic randomize_fog_settings(input int phase);
		logic [15:0] near_v;
		logic [15:0] far_v;
		int unsigned reach;
		near_v = 16'($urandom);
		far_v = 16'($urandom);
		case (phase)
			0: begin
				near_v = 16'h0000;
				far_v = 16'hFFFF;
			end
			1: begin
				near_v = 16'hFFFF;
				far_v = 16'h0000;
			end
			2: far_v = near_v;
			3: begin
				near_v = 16'($urandom_range(0, 65534));
				far_v = near_v + 16'd1;
			end
			default: begin
				if ($urandom_range(0, 1) == 0) begin
					reach = near_v + $urandom_range(1, 2000);
					far_v = (reach > 16'hFFFF) ? 16'hFFFF : 16'(reach);
				end
			end
		endcase
		write_fog_reg(lfb_pkg::REG_FOG_ENABLE, (16'($urandom) & 16'hFFFE) | 16'(phase != 5));
		write_fog_reg(lfb_pkg::REG_FOG_NEAR, near_v);
		write_fog_reg(lfb_pkg::REG_FOG_FAR, far_v);
		if (phase == 0) begin
			write_fog_reg(lfb_pkg::REG_FOG_RED, 16'hFFFF);
			write_fog_reg(lfb_pkg::REG_FOG_GREEN, 16'hFFFF);
			write_fog_reg(lfb_pkg::REG_FOG_BLUE, 16'hFFFF);
		end else if (phase == 1) begin
			write_fog_reg(lfb_pkg::REG_FOG_RED, 16'h0000);
			write_fog_reg(lfb_pkg::REG_FOG_GREEN, 16'h0000);
			write_fog_reg(lfb_pkg::REG_FOG_BLUE, 16'h0000);
		end else begin
			write_fog_reg(lfb_pkg::REG_FOG_RED, 16'($urandom));
			write_fog_reg(lfb_pkg::REG_FOG_GREEN, 16'($urandom));
			write_fog_reg(lfb_pkg::REG_FOG_BLUE, 16'($urandom));
		end
		if (phase % 2 == 1) begin
			write_fog_reg(REG_UNMAPPED_LO, 16'($urandom));
			write_fog_reg(REG_UNMAPPED_HI, 16'($urandom));
		end
	endtask

	task automatic test_reset_defaults();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		// fog is off out of reset
		send_pixel(16'd0, {8'hFF, 8'h00, 8'h80, 8'h5A});
		send_pixel(16'hFFFF, {8'h00, 8'hFF, 8'h7F, 8'hA5});
		wait_core_empty();
		write_fog_reg(lfb_pkg::REG_FOG_ENABLE, 16'h0001);
		send_pixel(16'd200, {8'h10, 8'h20, 8'h30, 8'hFF});
		send_pixel(16'd201, {8'hFF, 8'hFF, 8'hFF, 8'h00});
		send_pixel(16'd700, {8'h00, 8'h00, 8'h00, 8'h01});
		send_pixel(16'd1199, {8'hFF, 8'h00, 8'hFF, 8'h80});
		send_pixel(16'd1200, {8'h01, 8'hFE, 8'h55, 8'h7F});
	endtask

	task automatic test_fog_extremes();
		wait_core_empty();
		write_fog_reg(lfb_pkg::REG_FOG_NEAR, 16'h0000);
		write_fog_reg(lfb_pkg::REG_FOG_FAR, 16'hFFFF);
		write_fog_reg(lfb_pkg::REG_FOG_RED, 16'h00FF);
		write_fog_reg(lfb_pkg::REG_FOG_GREEN, 16'h0000);
		write_fog_reg(lfb_pkg::REG_FOG_BLUE, 16'h00FF);
		send_pixel(16'd0, {8'h00, 8'hFF, 8'h00, 8'hFF});
		send_pixel(16'd1, {8'hFF, 8'h00, 8'hFF, 8'h00});
		send_pixel(16'hFFFE, {8'h00, 8'hFF, 8'h00, 8'h33});
		send_pixel(16'hFFFF, {8'h00, 8'hFF, 8'h00, 8'hCC});
		// far equal to near, then far below near
		wait_core_empty();
		write_fog_reg(lfb_pkg::REG_FOG_NEAR, 16'd1000);
		write_fog_reg(lfb_pkg::REG_FOG_FAR, 16'd1000);
		send_pixel(16'd1000, {8'h12, 8'h34, 8'h56, 8'h78});
		send_pixel(16'd1001, {8'h12, 8'h34, 8'h56, 8'h78});
		wait_core_empty();
		write_fog_reg(lfb_pkg::REG_FOG_NEAR, 16'hFFFE);
		write_fog_reg(lfb_pkg::REG_FOG_FAR, 16'h0000);
		send_pixel(16'hFFFE, {8'h9A, 8'hBC, 8'hDE, 8'hF0});
		send_pixel(16'hFFFF, {8'h9A, 8'hBC, 8'hDE, 8'hF0});
	endtask

	task automatic test_register_masking();
		wait_core_empty();
		write_fog_reg(REG_UNMAPPED_LO, 16'hFFFF);
		write_fog_reg(REG_UNMAPPED_HI, 16'hFFFF);
		send_pixel(16'h8000, {8'h40, 8'h80, 8'hC0, 8'h11});
		wait_core_empty();
		write_fog_reg(lfb_pkg::REG_FOG_ENABLE, 16'hFFFE);
		send_pixel(16'hFFFF, {8'hAA, 8'h55, 8'hAA, 8'h55});
		wait_core_empty();
		write_fog_reg(lfb_pkg::REG_FOG_RED, 16'hFF00);
		write_fog_reg(lfb_pkg::REG_FOG_ENABLE, 16'h8001);
		send_pixel(16'hFFFF, {8'hFF, 8'h0F, 8'hF0, 8'h22});
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 12; phase++) begin
			wait_core_empty();
			randomize_fog_settings(phase);
			tx_idle_on = (phase % 4 != 3);
			rx_idle_on = (phase % 3 != 2);
			for (int n = 0; n < 85; n++)
				send_pixel(random_depth(), random_pixel());
		end
	endtask

	task automatic test_output_hold_off();
		wait_core_empty();
		randomize_fog_settings(6);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		hold_len = 80;
		hold_request = 1'b1;
		for (int n = 0; n < 60; n++)
			send_pixel(random_depth(), random_pixel());
	endtask

	task automatic test_full_rate_stream();
		wait_core_empty();
		randomize_fog_settings(7);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		for (int n = 0; n < 100; n++)
			send_pixel(random_depth(), random_pixel());
	endtask

	// receiver side stalls
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (hold_len) @(posedge clk);
				out_stall <= 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : item_monitor
		fogged_t got;
		fogged_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.pix = {out_red, out_green, out_blue, out_alpha};
			got.factor = fog_factor;
			if (pending_fogged.size() == 0) begin
				fail_count++;
				$display("%0t unexpected item: expected none actual %0h", $time, got);
			end else begin
				want = pending_fogged.pop_front();
				check_field("out_red", want.pix.red, got.pix.red);
				check_field("out_green", want.pix.green, got.pix.green);
				check_field("out_blue", want.pix.blue, got.pix.blue);
				check_field("out_alpha", want.pix.alpha, got.pix.alpha);
				check_field("fog_factor", want.factor, got.factor);
			end
		end
		if (arst_n && in_valid && !in_stall)
			pending_fogged.push_back(fog_pixel(depth,
				{pixel_red, pixel_green, pixel_blue, pixel_alpha}));
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("linear_fog_blend_core verification failed");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_fog_extremes();
		test_register_masking();
		test_random_settings();
		test_output_hold_off();
		test_full_rate_stream();
		wait_core_empty();
		repeat (LATENCY + 4) @(posedge clk);
		if (fail_count == 0)
			$display("linear_fog_blend_core verification clean");
		else
			$display("linear_fog_blend_core verification failed");
		$finish;
	end

endmodule
